// ===== sv/mtpm_pkg.sv =====
// Shared constants, types and constant table functions for the Mercator tile mapper.
`default_nettype none

package mtpm_pkg;

	// Angle format and limits
	localparam int ANGLE_FRAC_BITS = 22;
	localparam int MAX_ZOOM        = 20;
	localparam logic signed [31:0] LAT_LIM = 32'(86 << ANGLE_FRAC_BITS);
	localparam logic signed [31:0] LON_LIM = 32'(180 << ANGLE_FRAC_BITS);
	localparam int GX_SHIFT = ANGLE_FRAC_BITS + 3;

	// Pipeline geometry
	localparam int COR_STEPS = 60;
	localparam int HYP_STEPS = 63;
	localparam int LN_LAT    = HYP_STEPS + 5;

	// Q60 reals and fixed constants
	localparam logic [63:0] Q_ONE      = 64'h1000_0000_0000_0000;
	localparam logic [63:0] Q_HALF     = 64'h0800_0000_0000_0000;
	localparam logic [63:0] PI_Q62     = 64'hC90F_DAA2_2168_C235;
	localparam logic [63:0] LN2_Q60    = 64'h0B17_217F_7D1C_F79B;
	localparam logic [63:0] INV2PI_Q64 = 64'h28BE_60DB_9391_054B;
	localparam logic [63:0] PHI_K      = PI_Q62 / 64'd45;

	// Division by 45 through reciprocals
	localparam logic [31:0] DIV45_R      = 32'd3054198967;
	localparam int          DIV45_SH     = 37;
	localparam logic [14:0] DIV45_R_SML  = 15'd23302;
	localparam int          DIV45_SH_SML = 20;

	// Configuration register map
	localparam logic ADDR_TILE_SIZE = 1'b0;

	// Per-item control carried along the pipeline
	typedef struct packed {
		logic        ok;
		logic        lat_neg;
		logic [5:0]  s;
		logic [3:0]  tb;
		logic [30:0] gx;
	} ctl_t;

	// Arithmetic right shift of a 64-bit word
	function automatic logic [63:0] asr(input logic [63:0] v, input int n);
		return 64'($signed(v) >>> n);
	endfunction

	// Series sum of atan or atanh(2^-i) in Q62, rounded to Q60
	function automatic logic [63:0] series_q60(input int i, input bit alt);
		logic [63:0] sum;
		logic [63:0] term;
		sum = 64'd0;
		for (int k = 0; k < 32; k++) begin
			if ((2 * k + 1) * i <= 62) begin
				term = (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
				if (alt && k[0]) sum = sum - term;
				else sum = sum + term;
			end
		end
		return (sum + 64'd2) >> 2;
	endfunction

	function automatic logic [63:0] atan_val(input int i);
		return (i == 0) ? (PI_Q62 >> 4) : series_q60(i, 1'b1);
	endfunction

	function automatic logic [63:0] atanh_val(input int i);
		return (i == 0) ? 64'd0 : series_q60(i, 1'b0);
	endfunction

	// Hyperbolic step shift; steps 4, 13 and 40 appear twice
	function automatic int hyp_shift(input int j);
		if (j < 4) return j + 1;
		else if (j < 14) return j;
		else if (j < 42) return j - 1;
		else return j - 2;
	endfunction

endpackage

`default_nettype wire

// ===== sv/mercator_tile_pixel_mapper_top.sv =====
// Web Mercator tile mapper: projects latitude/longitude/zoom to pixel and tile coordinates.
//
// Input stream (s_*): one transaction per point, latitude and longitude in
// signed units of 2^-22 degree and a zoom level. Output stream (m_*): one
// transaction per input, with m_tuser set when the point lies inside the
// projected world; all coordinates read zero otherwise.
// The APB port holds the tile size code (edge 256 << code pixels); write it
// only while no point is in flight.
// The pipeline has 141 register stages. Throughput is one point per cycle
// while m_tready does not hold the pipeline: every stage is a register stage.
// The depth is set by the 60-step circular CORDIC, two 63-step hyperbolic
// CORDIC log units and the split 64x64 multiply for the row fraction.
// The whole pipeline advances together; when the receiver holds m_tready low
// with a result waiting, every stage holds and s_tready drops, so nothing is
// lost or repeated.
// Reset clears all valid bits and the tile size code (256-pixel tiles); the
// block takes input in the first cycle after reset is released.
`default_nettype none

module mercator_tile_pixel_mapper_top
	import mtpm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,  // latitude[31:0], longitude[63:32], zoom[68:64], zero pad
	// Output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // global_x, global_y, tile_x, tile_y, pixel_x, pixel_y, pad
	output logic [0:0]   m_tuser   // valid_res
);

	// Configuration register
	logic [1:0] tsc_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsc_q <= 2'd0;
		end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_TILE_SIZE) begin
			tsc_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == ADDR_TILE_SIZE) ? {30'd0, tsc_q} : 32'd0;

	// Global advance
	logic adv;
	logic out_vld_s13;

	assign adv      = !out_vld_s13 || m_tready;
	assign s_tready = adv;

	// Stage 1: range checks, |lat|, shifted longitude
	logic signed [31:0] lat_c;
	logic signed [31:0] lon_c;
	logic [4:0]         zoom_c;
	logic [31:0]        lonu_c;
	ctl_t               ctl_c;

	logic        vld_s1;
	ctl_t        ctl_s1;
	logic [31:0] a_s1;
	logic [30:0] lonu_s1;

	always_comb begin
		lat_c  = s_tdata[31:0];
		lon_c  = s_tdata[63:32];
		zoom_c = s_tdata[68:64];
		lonu_c = 32'(lon_c + LON_LIM);
		ctl_c.ok = (zoom_c <= 5'(MAX_ZOOM)) && (lat_c <= LAT_LIM) && (lat_c >= -LAT_LIM)
			&& (lon_c < LON_LIM) && (lon_c >= -LON_LIM);
		ctl_c.lat_neg = lat_c[31];
		ctl_c.s  = 6'(zoom_c) + 6'd8 + 6'(tsc_q);
		ctl_c.tb = 4'd8 + 4'(tsc_q);
		ctl_c.gx = 31'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1  <= ctl_c;
			a_s1    <= lat_c[31] ? (~lat_c + 32'd1) : lat_c;
			lonu_s1 <= lonu_c[30:0];
		end
	end

	// Stage 2: angle scaling partial products, reciprocal of 45
	logic        vld_s2;
	ctl_t        ctl_s2;
	logic [63:0] mlo_s2;
	logic [63:0] mhi_s2;
	logic [62:0] qm_s2;
	logic [30:0] lonu_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2  <= ctl_s1;
			mlo_s2  <= a_s1 * PHI_K[31:0];
			mhi_s2  <= a_s1 * PHI_K[63:32];
			qm_s2   <= lonu_s1 * DIV45_R;
			lonu_s2 <= lonu_s1;
		end
	end

	// Stage 3: phi in Q60, half angle, lon_u/45
	logic [95:0] prod_c;
	logic        vld_s3;
	ctl_t        ctl_s3;
	logic [63:0] z0_s3;
	logic [25:0] q1_s3;
	logic [30:0] lonu_s3;

	assign prod_c = {32'd0, mlo_s2} + {mhi_s2, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3  <= ctl_s2;
			z0_s3   <= {1'b0, prod_c[89:27]};
			q1_s3   <= qm_s2[DIV45_SH +: 26];
			lonu_s3 <= lonu_s2;
		end
	end

	// Stage 4: remainder of lon_u/45
	logic [30:0] r1_c;
	logic        vld_s4;
	ctl_t        ctl_s4;
	logic [63:0] z0_s4;
	logic [25:0] q1_s4;
	logic [5:0]  r1_s4;

	assign r1_c = lonu_s3 - 31'(q1_s3 * 31'd45);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_s3;
			z0_s4  <= z0_s3;
			q1_s4  <= q1_s3;
			r1_s4  <= r1_c[5:0];
		end
	end

	// Stage 5: scale up by 2^(s-25) where s is large
	logic [5:0]  mup_c;
	logic [2:0]  m_c;
	logic [11:0] x2_c;
	logic [26:0] q2p_c;
	logic        vld_s5;
	ctl_t        ctl_s5;
	logic [63:0] z0_s5;
	logic [31:0] hiq_s5;
	logic [5:0]  q2_s5;

	always_comb begin
		mup_c = ctl_s4.s - 6'(GX_SHIFT);
		m_c   = (ctl_s4.s >= 6'(GX_SHIFT)) ? mup_c[2:0] : 3'd0;
		x2_c  = 12'(r1_s4) << m_c;
		q2p_c = x2_c * DIV45_R_SML;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5 <= ctl_s4;
			z0_s5  <= z0_s4;
			hiq_s5 <= 32'(q1_s4) << m_c;
			q2_s5  <= q2p_c[DIV45_SH_SML +: 6];
		end
	end

	// Stage 6: global column, seeds the circular CORDIC
	logic [31:0] d_c;
	logic [5:0]  ndn_c;
	logic [4:0]  n_c;
	ctl_t        ctl6_c;

	logic [63:0] cor_x [0:COR_STEPS];
	logic [63:0] cor_y [0:COR_STEPS];
	logic [63:0] cor_z [0:COR_STEPS];
	ctl_t        cor_c [0:COR_STEPS];
	logic        cor_v [0:COR_STEPS];

	always_comb begin
		d_c    = hiq_s5 + 32'(q2_s5);
		ndn_c  = 6'(GX_SHIFT) - ctl_s5.s;
		n_c    = (ctl_s5.s < 6'(GX_SHIFT)) ? ndn_c[4:0] : 5'd0;
		ctl6_c = ctl_s5;
		ctl6_c.gx = 31'(d_c >> n_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cor_v[0] <= 1'b0;
		else if (adv) cor_v[0] <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cor_x[0] <= Q_ONE;
			cor_y[0] <= 64'd0;
			cor_z[0] <= z0_s5;
			cor_c[0] <= ctl6_c;
		end
	end

	// Circular CORDIC rotation by half the latitude
	for (genvar i = 0; i < COR_STEPS; i++) begin : g_cor
		localparam logic [63:0] ATN = atan_val(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cor_v[i+1] <= 1'b0;
			else if (adv) cor_v[i+1] <= cor_v[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cor_z[i][63]) begin
					cor_x[i+1] <= cor_x[i] - asr(cor_y[i], i);
					cor_y[i+1] <= cor_y[i] + asr(cor_x[i], i);
					cor_z[i+1] <= cor_z[i] - ATN;
				end else begin
					cor_x[i+1] <= cor_x[i] + asr(cor_y[i], i);
					cor_y[i+1] <= cor_y[i] - asr(cor_x[i], i);
					cor_z[i+1] <= cor_z[i] + ATN;
				end
				cor_c[i+1] <= cor_c[i];
			end
		end
	end

	// Stage 7: x+y and x-y for the two logarithms
	logic [63:0] u_s7;
	logic [63:0] w_s7;
	ctl_t        dl_c [0:LN_LAT];
	logic        dl_v [0:LN_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dl_v[0] <= 1'b0;
		else if (adv) dl_v[0] <= cor_v[COR_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s7     <= cor_x[COR_STEPS] + cor_y[COR_STEPS];
			w_s7     <= cor_x[COR_STEPS] - cor_y[COR_STEPS];
			dl_c[0]  <= cor_c[COR_STEPS];
		end
	end

	// Control delay alongside the log units
	for (genvar j = 0; j < LN_LAT; j++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dl_v[j+1] <= 1'b0;
			else if (adv) dl_v[j+1] <= dl_v[j];
		end
		always_ff @(posedge clk) begin
			if (adv) dl_c[j+1] <= dl_c[j];
		end
	end

	logic [63:0] lnu;
	logic [63:0] lnw;

	mtpm_ln_pipe u_ln_sum (
		.clk    (clk),
		.en     (adv),
		.val    (u_s7),
		.ln_out (lnu)
	);

	mtpm_ln_pipe u_ln_dif (
		.clk    (clk),
		.en     (adv),
		.val    (w_s7),
		.ln_out (lnw)
	);

	// Stage 8: psi, negative taken as zero
	logic [63:0] psi_c;
	logic        vld_s8;
	ctl_t        ctl_s8;
	logic [63:0] psi_s8;

	assign psi_c = lnu - lnw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (adv) vld_s8 <= dl_v[LN_LAT];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s8 <= dl_c[LN_LAT];
			psi_s8 <= psi_c[63] ? 64'd0 : psi_c;
		end
	end

	// Stages 9 to 11: high half of psi * 1/(2 pi)
	logic        vld_s9;
	ctl_t        ctl_s9;
	logic [31:0] psih_s9;
	logic [63:0] pp00_s9;
	logic [63:0] pp01_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else if (adv) vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s9  <= ctl_s8;
			psih_s9 <= psi_s8[63:32];
			pp00_s9 <= psi_s8[31:0] * INV2PI_Q64[31:0];
			pp01_s9 <= psi_s8[31:0] * INV2PI_Q64[63:32];
		end
	end

	logic        vld_s10;
	ctl_t        ctl_s10;
	logic [63:0] pp00_s10;
	logic [63:0] pp01_s10;
	logic [63:0] pp10_s10;
	logic [63:0] pp11_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s10 <= 1'b0;
		else if (adv) vld_s10 <= vld_s9;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s10  <= ctl_s9;
			pp00_s10 <= pp00_s9;
			pp01_s10 <= pp01_s9;
			pp10_s10 <= psih_s9 * INV2PI_Q64[31:0];
			pp11_s10 <= psih_s9 * INV2PI_Q64[63:32];
		end
	end

	logic [33:0] mid_c;
	logic        vld_s11;
	ctl_t        ctl_s11;
	logic [63:0] q_s11;

	assign mid_c = 34'(pp00_s10[63:32]) + 34'(pp01_s10[31:0]) + 34'(pp10_s10[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s11 <= 1'b0;
		else if (adv) vld_s11 <= vld_s10;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s11 <= ctl_s10;
			q_s11   <= pp11_s10 + 64'(pp01_s10[63:32]) + 64'(pp10_s10[63:32])
				+ 64'(mid_c[33:32]);
		end
	end

	// Stage 12: row fraction and global row
	logic [63:0] t_c;
	logic [5:0]  gysh_c;
	logic        ok12_c;
	logic        vld_s12;
	logic        ok_s12;
	logic [3:0]  tb_s12;
	logic [30:0] gx_s12;
	logic [30:0] gy_s12;

	always_comb begin
		t_c    = ctl_s11.lat_neg ? (Q_HALF + q_s11) : (Q_HALF - q_s11);
		gysh_c = 6'd60 - ctl_s11.s;
		ok12_c = ctl_s11.ok && (t_c[63:60] == 4'd0)
			&& !(!ctl_s11.lat_neg && (q_s11 > Q_HALF));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s12 <= 1'b0;
		else if (adv) vld_s12 <= vld_s11;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s12 <= ok12_c;
			tb_s12 <= ctl_s11.tb;
			gx_s12 <= ctl_s11.gx;
			gy_s12 <= 31'(t_c >> gysh_c);
		end
	end

	// Stage 13: output register, tile split
	logic [30:0] pmask_c;
	logic [30:0] gx13_s13;
	logic [30:0] gy13_s13;
	logic [19:0] tx_s13;
	logic [19:0] ty_s13;
	logic [10:0] px_s13;
	logic [10:0] py_s13;
	logic        ok_s13;
	logic [3:0]  out_tb_s13;

	assign pmask_c = (31'd1 << tb_s12) - 31'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_s13 <= 1'b0;
		else if (adv) out_vld_s13 <= vld_s12;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s13     <= ok_s12;
			out_tb_s13 <= tb_s12;
			if (ok_s12) begin
				gx13_s13 <= gx_s12;
				gy13_s13 <= gy_s12;
				tx_s13   <= 20'(gx_s12 >> tb_s12);
				ty_s13   <= 20'(gy_s12 >> tb_s12);
				px_s13   <= 11'(gx_s12 & pmask_c);
				py_s13   <= 11'(gy_s12 & pmask_c);
			end else begin
				gx13_s13 <= 31'd0;
				gy13_s13 <= 31'd0;
				tx_s13   <= 20'd0;
				ty_s13   <= 20'd0;
				px_s13   <= 11'd0;
				py_s13   <= 11'd0;
			end
		end
	end

	assign m_tvalid = out_vld_s13;
	assign m_tuser  = ok_s13;
	assign m_tdata  = {4'd0, py_s13, px_s13, ty_s13, tx_s13, gy13_s13, gx13_s13};

	// Checks
	ap_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 128'd0)
		else $error("invalid result carries non-zero coordinates");

	ap_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((px_s13 >> out_tb_s13) == 11'd0) && ((py_s13 >> out_tb_s13) == 11'd0))
		else $error("in-tile pixel not below tile size");

	ap_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

endmodule

`default_nettype wire

// ===== sv/mtpm_ln_pipe.sv =====
// Pipelined natural logarithm of a Q60 word: normalise, hyperbolic CORDIC, add k*ln2.
`default_nettype none

module mtpm_ln_pipe
	import mtpm_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] val,
	output logic [63:0] ln_out
);

	// Stage 1: per-byte leading one
	logic [7:0]       nz_c;
	logic [7:0][2:0]  pos_c;
	logic [63:0]      v_s1;
	logic [7:0]       nz_s1;
	logic [7:0][2:0]  pos_s1;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			nz_c[b]  = |val[8*b +: 8];
			pos_c[b] = 3'd0;
			for (int i = 0; i < 8; i++) begin
				if (val[8*b+i]) pos_c[b] = 3'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1   <= val;
			nz_s1  <= nz_c;
			pos_s1 <= pos_c;
		end
	end

	// Stage 2: top set bit and exponent k = p - 60
	logic [5:0]  p_c;
	logic [6:0]  k_c;
	logic [63:0] v_s2;
	logic [6:0]  k_s2;
	logic        zero_s2;

	always_comb begin
		p_c = 6'd0;
		for (int b = 0; b < 8; b++) begin
			if (nz_s1[b]) p_c = {3'(b), pos_s1[b]};
		end
		k_c = {1'b0, p_c} - 7'd60;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s2    <= v_s1;
			k_s2    <= k_c;
			zero_s2 <= ~|nz_s1;
		end
	end

	// Stage 3: mantissa in [1,2), seed X = m+1, Y = m-1
	logic [6:0]  kneg_c;
	logic [5:0]  sh_c;
	logic [63:0] m_c;

	logic [63:0] hx [0:HYP_STEPS];
	logic [63:0] hy [0:HYP_STEPS];
	logic [63:0] hz [0:HYP_STEPS];
	logic [6:0]  hk [0:HYP_STEPS];
	logic        hzero [0:HYP_STEPS];

	always_comb begin
		kneg_c = 7'd0 - k_s2;
		sh_c   = k_s2[6] ? kneg_c[5:0] : k_s2[5:0];
		m_c    = k_s2[6] ? (v_s2 << sh_c) : (v_s2 >> sh_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hx[0]    <= m_c + Q_ONE;
			hy[0]    <= m_c - Q_ONE;
			hz[0]    <= 64'd0;
			hk[0]    <= k_s2;
			hzero[0] <= zero_s2;
		end
	end

	// Hyperbolic vectoring, one step per stage
	for (genvar j = 0; j < HYP_STEPS; j++) begin : g_hyp
		localparam int          SH  = hyp_shift(j);
		localparam logic [63:0] ATH = atanh_val(SH);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!hy[j][63]) begin
					hx[j+1] <= hx[j] - asr(hy[j], SH);
					hy[j+1] <= hy[j] - asr(hx[j], SH);
					hz[j+1] <= hz[j] + ATH;
				end else begin
					hx[j+1] <= hx[j] + asr(hy[j], SH);
					hy[j+1] <= hy[j] + asr(hx[j], SH);
					hz[j+1] <= hz[j] - ATH;
				end
				hk[j+1]    <= hk[j];
				hzero[j+1] <= hzero[j];
			end
		end
	end

	// k*ln2 product
	logic [6:0]  kmag_c;
	logic [63:0] kl_sr1;
	logic [63:0] zs_sr1;
	logic        kneg_sr1;
	logic        zero_sr1;

	always_comb begin
		kmag_c = hk[HYP_STEPS][6] ? (7'd0 - hk[HYP_STEPS]) : hk[HYP_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kl_sr1   <= {57'd0, kmag_c} * LN2_Q60;
			zs_sr1   <= hz[HYP_STEPS] << 1;
			kneg_sr1 <= hk[HYP_STEPS][6];
			zero_sr1 <= hzero[HYP_STEPS];
		end
	end

	// Final sum; ln of zero reads as zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_sr1) ln_out <= 64'd0;
			else if (kneg_sr1) ln_out <= zs_sr1 - kl_sr1;
			else ln_out <= zs_sr1 + kl_sr1;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_mercator_tile_pixel_mapper_top.sv =====
// Self-checking testbench for the Web Mercator tile mapper: stream stimulus, APB set-up, scoreboard.
`default_nettype none

module tb_mercator_tile_pixel_mapper_top
	import mtpm_pkg::*;
();

	localparam logic [2:0] REG_TILE_SIZE = 3'd0;
	localparam int         DRAIN_CYCLES  = 160;
	localparam int         HOLD_CYCLES   = 400;

	// Idling modes
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic        ok;
		logic [30:0] gx;
		logic [30:0] gy;
		logic [19:0] tx;
		logic [19:0] ty;
		logic [10:0] px;
		logic [10:0] py;
	} tile_res_t;

	typedef struct packed {
		logic signed [31:0] lat;
		logic signed [31:0] lon;
		logic [4:0]         zoom;
	} point_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;

	point_t     point_q[$];
	tile_res_t  tile_exp_q[$];
	logic [1:0] size_code;
	idle_mode_t idle_mode;
	int         mismatches;
	bit         hold_req, hold_done;
	int         hold_cnt;

	logic [63:0] atan_lut[60];
	logic [63:0] atanh_lut[61];

	mercator_tile_pixel_mapper_top dut (.*);

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Q62 power series for atan/atanh(2^-i), rounded to Q60
	function automatic logic [63:0] arc_series(input int i, input bit alternating);
		logic [63:0] acc;
		logic [63:0] term;
		acc = 64'd0;
		for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
			term = (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
			if (alternating && (k % 2 == 1)) acc = acc - term;
			else acc = acc + term;
		end
		return (acc + 64'd2) >> 2;
	endfunction

	function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b,
			input int n);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> n);
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
		return 64'($signed(v) >>> n);
	endfunction

	// Natural log of a positive Q60 value by hyperbolic vectoring
	function automatic logic [63:0] log_q60(input logic [63:0] v);
		int          msb, k, reps;
		logic [63:0] m, hx, hy, hz, xs, ys, r;
		if (v == 64'd0) return 64'd0;
		msb = 63;
		while (v[msb] == 1'b0) msb--;
		k  = msb - 60;
		m  = (k >= 0) ? (v >> k) : (v << (-k));
		hx = m + Q_ONE;
		hy = m - Q_ONE;
		hz = 64'd0;
		for (int i = 1; i <= 60; i++) begin
			reps = (i == 4 || i == 13 || i == 40) ? 2 : 1;
			for (int rr = 0; rr < reps; rr++) begin
				xs = sra64(hx, i);
				ys = sra64(hy, i);
				if (!hy[63]) begin
					hx = hx - ys; hy = hy - xs; hz = hz + atanh_lut[i];
				end else begin
					hx = hx + ys; hy = hy + xs; hz = hz - atanh_lut[i];
				end
			end
		end
		r = hz << 1;
		if (k >= 0) r = r + 64'(k) * LN2_Q60;
		else r = r - 64'(-k) * LN2_Q60;
		return r;
	endfunction

	// Projected tile/pixel coordinates of one point
	function automatic tile_res_t project(input point_t p, input logic [1:0] code);
		tile_res_t   res;
		int          tb, s;
		logic [63:0] lon_u, gx, gy, a, phi, cx, cy, cz, xs, ys, psi, q, t;
		res = '0;
		if (p.zoom > MAX_ZOOM || p.lat > LAT_LIM || p.lat < -LAT_LIM ||
				p.lon > LON_LIM || p.lon < -LON_LIM)
			return res;
		tb = 8 + code;
		s  = int'(p.zoom) + tb;
		lon_u = 64'(longint'(p.lon) + longint'(LON_LIM));
		if (s >= 25) gx = (lon_u << (s - 25)) / 64'd45;
		else gx = lon_u / (64'd45 << (25 - s));
		if ((gx >> s) != 0) return res;
		a   = 64'(p.lat < 0 ? -longint'(p.lat) : longint'(p.lat));
		phi = mul_hi(a, PI_Q62 / 64'd45, 26);
		cx = Q_ONE; cy = 64'd0; cz = phi >> 1;
		for (int i = 0; i < 60; i++) begin
			xs = sra64(cx, i);
			ys = sra64(cy, i);
			if (!cz[63]) begin
				cx = cx - ys; cy = cy + xs; cz = cz - atan_lut[i];
			end else begin
				cx = cx + ys; cy = cy - xs; cz = cz + atan_lut[i];
			end
		end
		psi = log_q60(cx + cy) - log_q60(cx - cy);
		if (psi[63]) psi = 64'd0;
		q = mul_hi(psi, INV2PI_Q64, 64);
		if (p.lat < 0) t = Q_HALF + q;
		else if (q > Q_HALF) return res;
		else t = Q_HALF - q;
		gy = t >> (60 - s);
		if ((gy >> s) != 0) return res;
		res.ok = 1'b1;
		res.gx = gx[30:0];
		res.gy = gy[30:0];
		res.tx = 20'(gx >> tb);
		res.ty = 20'(gy >> tb);
		res.px = 11'(gx & ((64'd1 << tb) - 1));
		res.py = 11'(gy & ((64'd1 << tb) - 1));
		return res;
	endfunction

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit sender_waits();
		case (idle_mode)
			IDLE_SEND: return roll(54);
			IDLE_BOTH: return roll(20);
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return roll(54);
			IDLE_BOTH: return roll(20);
			default:   return 1'b0;
		endcase
	endfunction

	// Random point: mostly in range, some near the limits, some raw noise
	function automatic point_t rand_point();
		point_t p;
		int     r;
		r = $urandom_range(99);
		if (r < 70) begin
			p.lat  = $signed($urandom_range(0, 2 * LAT_LIM)) - LAT_LIM;
			p.lon  = $signed($urandom_range(0, 2 * LON_LIM)) - LON_LIM;
			p.zoom = 5'($urandom_range(0, MAX_ZOOM));
		end else if (r < 85) begin
			// polar edge of the projected world and the antimeridian
			p.lat  = LAT_LIM - $signed($urandom_range(0, 32'd5 << ANGLE_FRAC_BITS));
			if (roll(50)) p.lat = -p.lat;
			p.lon  = roll(50) ? LON_LIM - $signed($urandom_range(0, 3))
				: -LON_LIM + $signed($urandom_range(0, 3));
			p.zoom = 5'($urandom_range(0, MAX_ZOOM));
		end else begin
			p.lat  = $urandom;
			p.lon  = $urandom;
			p.zoom = 5'($urandom);
		end
		return p;
	endfunction

	task automatic add_point(input logic signed [31:0] lat, input logic signed [31:0] lon,
			input logic [4:0] zoom);
		point_q.push_back('{lat: lat, lon: lon, zoom: zoom});
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == REG_TILE_SIZE) size_code = data[1:0];
	endtask

	task automatic wait_drained();
		while (point_q.size() != 0 || s_tvalid || tile_exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (point_q.size() != 0 && !sender_waits()) begin
				s_tdata  <= {3'b000, point_q[0].zoom, point_q[0].lon, point_q[0].lat};
				s_tvalid <= 1'b1;
				void'(point_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt > 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
			if (hold_cnt == 1) hold_done <= 1'b1;
		end else if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_cnt <= HOLD_CYCLES;
		end else begin
			m_tready <= !receiver_stalls();
		end
	end

	// Accepted input transactions become expectations
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			tile_exp_q.push_back(project('{lat: s_tdata[31:0], lon: s_tdata[63:32],
				zoom: s_tdata[68:64]}, size_code));
	end

	// Output transactions against the oldest expectation
	always @(posedge clk) begin
		tile_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser[0], m_tdata[30:0], m_tdata[61:31], m_tdata[81:62],
				m_tdata[101:82], m_tdata[112:102], m_tdata[123:113]};
			if (tile_exp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = tile_exp_q.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: ok %b/%b gx %0d/%0d gy %0d/%0d tx %0d/%0d ty %0d/%0d px %0d/%0d py %0d/%0d",
							want.ok, got.ok, want.gx, got.gx, want.gy, got.gy,
							want.tx, got.tx, want.ty, got.ty, want.px, got.px,
							want.py, got.py);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	// Sequence of phases
	initial begin
		logic [1:0] codes[6];
		idle_mode_t modes[6];
		codes = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
		modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV};
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tdata = '0;
		size_code = 2'd0;
		idle_mode = IDLE_NONE;
		mismatches = 0;
		hold_req = 1'b0;
		atan_lut[0] = PI_Q62 >> 4;
		for (int i = 1; i < 60; i++) atan_lut[i] = arc_series(i, 1'b1);
		atanh_lut[0] = 64'd0;
		for (int i = 1; i <= 60; i++) atanh_lut[i] = arc_series(i, 1'b0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			apb_write(REG_TILE_SIZE, {30'd0, codes[ph]});
			idle_mode = modes[ph];
			if (ph == 0) begin
				// limits of latitude, longitude and zoom
				add_point(0, 0, 0);
				add_point(LAT_LIM, 0, 5);
				add_point(-LAT_LIM, 0, 5);
				add_point(LAT_LIM + 1, 0, 5);
				add_point(-LAT_LIM - 1, 0, 5);
				add_point(0, LON_LIM, 3);
				add_point(0, -LON_LIM, 3);
				add_point(0, LON_LIM + 1, 3);
				add_point(0, -LON_LIM - 1, 3);
				add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd31);
				add_point(32'sh8000_0000, 32'sh8000_0000, 5'd0);
				add_point(32'sd356732000, 32'sd1000, 5'd20);   // just above the world edge
				add_point(-32'sd356732000, -32'sd1000, 5'd20);
				add_point(32'sd356800000, 32'sd1000, 5'd10);   // just above it
				add_point(-32'sd356800000, 32'sd1000, 5'd10);
				add_point(32'sd200000000, LON_LIM - 1, MAX_ZOOM);
				add_point(-32'sd200000000, -LON_LIM, MAX_ZOOM);
				add_point(1, -1, 5'd21);
				add_point(-1, 1, 5'd1);
				add_point(32'sd1234567, 32'sd7654321, 5'd12);
			end
			if (ph == 4) hold_req = 1'b1;
			repeat (130) point_q.push_back(rand_point());
			wait_drained();
		end

		if (mismatches == 0 && tile_exp_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/mtpm_pkg.sv
sv/mtpm_ln_pipe.sv
sv/mercator_tile_pixel_mapper_top.sv
tb/tb_mercator_tile_pixel_mapper_top.sv
